### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/sqvs_pkg.sv
// Package for the sprite quad vertex setup core: widths, register indexes, CORDIC table.
// Depends on nothing.
package sqvs_pkg;
    localparam int CordicSteps = 16;
    localparam int ZW = 26;
    localparam int CW = 36;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SHEET_COLUMNS = 2'd2;
    localparam logic [1:0] REG_SHEET_ROWS    = 2'd3;
    localparam int InWidth  = 136;
    localparam int OutWidth = 88;
    localparam int CfgWidth = 13;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            4'd0: r = 26'sd2097152;  4'd1: r = 26'sd1238021;
            4'd2: r = 26'sd654137;   4'd3: r = 26'sd332050;
            4'd4: r = 26'sd166669;   4'd5: r = 26'sd83416;
            4'd6: r = 26'sd41718;    4'd7: r = 26'sd20860;
            4'd8: r = 26'sd10430;    4'd9: r = 26'sd5215;
            4'd10: r = 26'sd2608;    4'd11: r = 26'sd1304;
            4'd12: r = 26'sd652;     4'd13: r = 26'sd326;
            4'd14: r = 26'sd163;     default: r = 26'sd81;
        endcase
        return r;
    endfunction
endpackage

### rtl/core/sqvs_seq.sv
// Per-vertex sequencer: holds one request and emits its six corners in order.
// Depends on sqvs_pkg.
module sqvs_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sqvs_pkg::InWidth-1:0] in_data,
    output logic                         o_valid,
    input  logic                         o_ready,
    output logic [sqvs_pkg::InWidth-1:0] o_data,
    output logic [2:0]                   o_num
);
    import sqvs_pkg::*;
    logic                 busy_reg, busy_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [InWidth-1:0]   data_reg;
    logic                 take;

    assign in_ready = !busy_reg || (o_ready && cnt_reg == 3'd5);
    assign take = in_valid && in_ready;
    assign o_valid = busy_reg;
    assign o_data = data_reg;
    assign o_num = cnt_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        if (busy_reg && o_ready)
        begin
            if (cnt_reg == 3'd5)
            begin
                busy_next = 1'b0;
                cnt_next = 3'd0;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= in_data;
        end
    end
endmodule

### rtl/core/sqvs_cordic.sv
// Sixteen-stage CORDIC rotation pipeline, one micro-rotation per register stage.
// Depends on sqvs_pkg.
module sqvs_cordic #(
    parameter int Steps = sqvs_pkg::CordicSteps
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [sqvs_pkg::CW-1:0] x_in,
    input  logic signed [sqvs_pkg::CW-1:0] y_in,
    input  logic signed [sqvs_pkg::ZW-1:0] z_in,
    output logic signed [sqvs_pkg::CW-1:0] x_out,
    output logic signed [sqvs_pkg::CW-1:0] y_out
);
    import sqvs_pkg::*;
    logic signed [CW-1:0] x_reg [Steps+1];
    logic signed [CW-1:0] y_reg [Steps+1];
    logic signed [ZW-1:0] z_reg [Steps+1];

    always_comb
    begin
        x_reg[0] = x_in;
        y_reg[0] = y_in;
        z_reg[0] = z_in;
    end

    for (genvar i = 0; i < Steps; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_lut(4'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_lut(4'(i));
                end
            end
        end
    end

    assign x_out = x_reg[Steps];
    assign y_out = y_reg[Steps];
endmodule

### rtl/core/sqvs_div.sv
// Pipelined restoring divider, one quotient bit per stage, remainder kept.
// Depends on nothing beyond its parameters.
module sqvs_div #(
    parameter int NW = 16,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    logic [NW-1:0] q_reg [NW+1];
    logic [DW:0]   r_reg [NW+1];
    logic [NW-1:0] n_reg [NW+1];
    logic [DW-1:0] d_reg [NW+1];

    always_comb
    begin
        q_reg[0] = '0;
        r_reg[0] = '0;
        n_reg[0] = num;
        d_reg[0] = den;
    end

    for (genvar i = 0; i < NW; i++)
    begin : g_bit
        logic [DW+1:0] t;
        assign t = {r_reg[i], n_reg[i][NW-1-i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i+1] <= n_reg[i];
                d_reg[i+1] <= d_reg[i];
                if (t >= {2'b00, d_reg[i]})
                begin
                    r_reg[i+1] <= (DW+1)'(t - {2'b00, d_reg[i]});
                    q_reg[i+1] <= q_reg[i] | (NW'(1) << (NW-1-i));
                end
                else
                begin
                    r_reg[i+1] <= (DW+1)'(t);
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    assign quo = q_reg[NW];
    assign rem = r_reg[NW][DW-1:0];
endmodule

### rtl/core/sprite_quad_vertex_setup_core.sv
// Sprite quad vertex setup core: one request in, six vertex beats out.
// Throughput: one vertex beat per cycle while the output is not stalled, set by the
// vertex sequencer, which can take a new request as the last beat of the previous
// one is accepted. Requests pass through the CORDIC, divider and texture pipelines.
// The pipeline stalls as a whole on output backpressure.
// Reset (rst_n, asynchronous, active low) clears valid bits and loads register defaults.
module sprite_quad_vertex_setup_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pos_x, pos_y, depth, width, height, anchor, angle, sheet_enable, frame,
    // cell_column, cell_row
    input  logic [sqvs_pkg::InWidth-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: ndc_x, ndc_y, vertex_depth, tex_u, tex_v, vertex_number
    output logic [sqvs_pkg::OutWidth-1:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [sqvs_pkg::CfgWidth-1:0] cfg_data
);
    import sqvs_pkg::*;
    localparam int Depth = 80;

    logic [12:0] scr_w_reg, scr_h_reg;
    logic [8:0]  cols_reg, rows_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 13'd1280;
            scr_h_reg <= 13'd720;
            cols_reg <= 9'd1;
            rows_reg <= 9'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                REG_SHEET_COLUMNS: cols_reg <= cfg_data[8:0];
                default:           rows_reg <= cfg_data[8:0];
            endcase
        end
    end

    // Sequencer
    logic              sq_valid, en;
    logic [InWidth-1:0] sq_data;
    logic [2:0]        sq_num;
    sqvs_seq u_seq (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata), .o_valid(sq_valid), .o_ready(en), .o_data(sq_data),
        .o_num(sq_num)
    );

    // Pipeline valid line and output register
    logic [Depth-1:0] vld_reg;
    logic             out_v_reg;
    assign en = !out_v_reg || m_tready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Depth-2:0], sq_valid};
            out_v_reg <= vld_reg[Depth-1];
        end
    end
    assign m_tvalid = out_v_reg;

    // Stage A: corner select and quadrant prerotation
    logic signed [15:0] pos_x, pos_y;
    logic [15:0] dep, wd, ht, ang, frm;
    logic [2:0]  anc;
    logic        shen;
    logic [7:0]  ccol, crow;
    assign {crow, ccol, frm, shen, ang, anc, ht, wd, dep, pos_y, pos_x} = sq_data[131:0];

    logic signed [CW-1:0] x0, x1, y0, y1, cxs, cys, rx, ry;
    logic signed [CW-1:0] wf, hf, wh, hh;
    logic [15:0] phi, rr;
    logic [1:0]  q;
    logic        isx1, isy0;
    always_comb
    begin
        wf = CW'($signed({1'b0, wd})) <<< 9;
        hf = CW'($signed({1'b0, ht})) <<< 9;
        wh = CW'($signed({1'b0, wd})) <<< 8;
        hh = CW'($signed({1'b0, ht})) <<< 8;
        unique case (anc)
            3'd1: begin x0 = -wf; x1 = '0; y0 = -hf; y1 = '0; end
            3'd2: begin x0 = '0; x1 = wf; y0 = '0; y1 = hf; end
            3'd3: begin x0 = -wf; x1 = '0; y0 = '0; y1 = hf; end
            3'd4: begin x0 = -wh; x1 = wh; y0 = -hh; y1 = hh; end
            default: begin x0 = '0; x1 = wf; y0 = -hf; y1 = '0; end
        endcase
        // vertex order NW,NE,SW,NE,SE,SW -> corners 0,1,2,1,3,2
        isx1 = (sq_num == 3'd1) || (sq_num == 3'd3) || (sq_num == 3'd4);
        isy0 = (sq_num == 3'd2) || (sq_num == 3'd4) || (sq_num == 3'd5);
        cxs = isx1 ? x1 : x0;
        cys = isy0 ? y0 : y1;
        phi = 16'd0 - ang;
        q = 2'(16'(phi + 16'h2000) >> 14);
        rr = phi - {q, 14'd0};
        unique case (q)
            2'd0: begin rx = cxs; ry = cys; end
            2'd1: begin rx = -cys; ry = cxs; end
            2'd2: begin rx = -cxs; ry = -cys; end
            default: begin rx = cys; ry = -cxs; end
        endcase
    end

    logic signed [CW-1:0] ax_reg, ay_reg;
    logic signed [ZW-1:0] az_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= rx;
            ay_reg <= ry;
            az_reg <= ZW'($signed(rr)) <<< 8;
        end
    end

    logic signed [CW-1:0] cx_o, cy_o;
    sqvs_cordic u_cordic (
        .clk(clk), .en(en), .x_in(ax_reg), .y_in(ay_reg), .z_in(az_reg),
        .x_out(cx_o), .y_out(cy_o)
    );

    // Side data delay line matching the CORDIC path (17 stages)
    localparam int SideW = 16 + 16 + 16 + 3 + 1;
    logic [SideW-1:0] side_reg [17];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {pos_x, pos_y, dep, sq_num, 1'b0};
            for (int i = 1; i < 17; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Gain correction multiply, then floor shift and position add
    logic signed [CW+16:0] gx_reg, gy_reg;
    logic [SideW-1:0]      sg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg <= (CW+17)'(cx_o) * (CW+17)'(39797) + (CW+17)'(32768);
            gy_reg <= (CW+17)'(cy_o) * (CW+17)'(39797) + (CW+17)'(32768);
            sg_reg <= side_reg[16];
        end
    end

    logic signed [CW-1:0] px_reg, py_reg;
    logic [SideW-1:0]     sp_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= CW'(gx_reg >>> 16) + (CW'($signed(sg_reg[51:36])) <<< 9);
            py_reg <= CW'(gy_reg >>> 16) + (CW'($signed(sg_reg[35:20])) <<< 9);
            sp_reg <= sg_reg;
        end
    end

    // ndc: floor((8p + w) / 2w) - 16384. Divide the magnitude; for a negative
    // numerator n use floor(n / d) = -((-n - 1) / d) - 1.
    logic [12:0] sw_eff, sh_eff;
    assign sw_eff = (scr_w_reg == 13'd0) ? 13'd1 : scr_w_reg;
    assign sh_eff = (scr_h_reg == 13'd0) ? 13'd1 : scr_h_reg;

    logic signed [CW+4:0] nx, ny;
    logic [CW+3:0] mx, my;
    logic sxn, syn;
    always_comb
    begin
        nx = ((CW+5)'(px_reg) <<< 3) + (CW+5)'(sw_eff);
        ny = ((CW+5)'(py_reg) <<< 3) + (CW+5)'(sh_eff);
        sxn = nx[CW+4];
        syn = ny[CW+4];
        mx = sxn ? (CW+4)'(-nx - 1) : (CW+4)'(nx);
        my = syn ? (CW+4)'(-ny - 1) : (CW+4)'(ny);
    end

    localparam int DivNW = CW + 4;
    logic [DivNW-1:0] qx, qy;
    logic [13:0] rx_u, ry_u;
    sqvs_div #(.NW(DivNW), .DW(14)) u_divx (
        .clk(clk), .en(en), .num(mx), .den({sw_eff, 1'b0}), .quo(qx), .rem(rx_u)
    );
    sqvs_div #(.NW(DivNW), .DW(14)) u_divy (
        .clk(clk), .en(en), .num(my), .den({sh_eff, 1'b0}), .quo(qy), .rem(ry_u)
    );

    // Texture: frame / cols, then / rows (pipelined dividers)
    // Side pipeline from sp stage carrying sign bits and pass-through data
    logic [8:0] cols_e, rows_e;
    assign cols_e = (cols_reg == 9'd0) ? 9'd1 : cols_reg;
    assign rows_e = (rows_reg == 9'd0) ? 9'd1 : rows_reg;

    // Request fields for texture are taken from the sequencer stage and delayed
    logic [15:0] t_frm_reg [19];
    logic [16:0] t_misc_reg [19];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_frm_reg[0] <= frm;
            t_misc_reg[0] <= {shen, crow, ccol};
            for (int i = 1; i < 19; i++)
            begin
                t_frm_reg[i] <= t_frm_reg[i-1];
                t_misc_reg[i] <= t_misc_reg[i-1];
            end
        end
    end

    logic [15:0] fq;
    logic [8:0]  fr;
    sqvs_div #(.NW(16), .DW(9)) u_divf (
        .clk(clk), .en(en), .num(t_frm_reg[18]), .den(cols_e), .quo(fq), .rem(fr)
    );
    logic [15:0] rq;
    logic [8:0]  rrow;
    sqvs_div #(.NW(16), .DW(9)) u_divr (
        .clk(clk), .en(en), .num(fq), .den(rows_e), .quo(rq), .rem(rrow)
    );

    // Delay misc by 32 stages to align with rrow (19 + 32 = 51 after sequencer)
    logic [16:0] m2_reg [32];
    logic [8:0]  fr_reg [16];
    logic [15:0] fz_reg [32];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg[0] <= t_misc_reg[18];
            fz_reg[0] <= t_frm_reg[18];
            fr_reg[0] <= fr;
            for (int i = 1; i < 32; i++)
            begin
                m2_reg[i] <= m2_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
            for (int i = 1; i < 16; i++)
            begin
                fr_reg[i] <= fr_reg[i-1];
            end
        end
    end

    // Cell select, registered at stage 52
    logic [8:0] col_reg, row_reg;
    logic       shen_reg;
    logic [2:0] tnum_reg;
    logic [2:0] num_d_reg [51];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shen_reg <= m2_reg[31][16];
            if (fz_reg[31] != 16'd0)
            begin
                col_reg <= fr_reg[15];
                row_reg <= rrow;
            end
            else
            begin
                col_reg <= {1'b0, m2_reg[31][7:0]};
                row_reg <= {1'b0, m2_reg[31][15:8]};
            end
            tnum_reg <= num_d_reg[50];
            num_d_reg[0] <= sq_num;
            for (int i = 1; i < 51; i++)
            begin
                num_d_reg[i] <= num_d_reg[i-1];
            end
        end
    end

    // Stage 53: pick cell index n and compute n*131072 + d
    logic [9:0]  un_sel, vn_sel;
    logic        ux1, vy0;
    logic [26:0] un_reg, vn_reg;
    logic        shen2_reg;
    always_comb
    begin
        ux1 = (tnum_reg == 3'd1) || (tnum_reg == 3'd3) || (tnum_reg == 3'd4);
        vy0 = (tnum_reg == 3'd2) || (tnum_reg == 3'd4) || (tnum_reg == 3'd5);
        un_sel = {1'b0, col_reg} + (ux1 ? 10'd1 : 10'd0);
        vn_sel = {1'b0, row_reg} + (vy0 ? 10'd1 : 10'd0);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg <= {un_sel, 17'd0} + 27'(cols_e);
            vn_reg <= {vn_sel, 17'd0} + 27'(rows_e);
            shen2_reg <= shen_reg;
        end
    end

    // Texture coordinate: floor((n*131072 + d) / 2d) over 27 stages, clamped to one
    // at the output.
    logic [26:0] uq, vq;
    logic [9:0]  ur_unused, vr_unused;
    sqvs_div #(.NW(27), .DW(10)) u_divu (
        .clk(clk), .en(en), .num(un_reg), .den({cols_e, 1'b0}), .quo(uq), .rem(ur_unused)
    );
    sqvs_div #(.NW(27), .DW(10)) u_divv (
        .clk(clk), .en(en), .num(vn_reg), .den({rows_e, 1'b0}), .quo(vq), .rem(vr_unused)
    );
    logic [26:0] shn_reg [27];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shn_reg[0] <= {26'd0, shen2_reg};
            for (int i = 1; i < 27; i++)
            begin
                shn_reg[i] <= shn_reg[i-1];
            end
        end
    end

    // Align geometry (ready at stage 19+40=59) with texture (stage 53+27=80):
    // delay geometry quotients by 21 stages.
    logic [DivNW-1:0] qx_d [21];
    logic [DivNW-1:0] qy_d [21];
    logic             sx_d [61];
    logic             sy_d [61];
    logic [15:0]      dep_d [61];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_d[0] <= qx;
            qy_d[0] <= qy;
            sx_d[0] <= sxn;
            sy_d[0] <= syn;
            dep_d[0] <= sp_reg[19:4];
            for (int i = 1; i < 21; i++)
            begin
                qx_d[i] <= qx_d[i-1];
                qy_d[i] <= qy_d[i-1];
            end
            for (int i = 1; i < 61; i++)
            begin
                sx_d[i] <= sx_d[i-1];
                sy_d[i] <= sy_d[i-1];
                dep_d[i] <= dep_d[i-1];
            end
        end
    end

    // Final: sign fix, offset, saturate; texture clamp
    logic signed [DivNW+1:0] fx, fy;
    logic [15:0] ox, oy;
    logic [16:0] ou, ov;
    logic [2:0]  fnum;
    logic [2:0]  num_out_reg;
    logic        sx_f, sy_f;
    assign sx_f = sx_d[60];
    assign sy_f = sy_d[60];
    always_comb
    begin
        fx = sx_f ? -$signed({2'b00, qx_d[20]}) - 1 : $signed({2'b00, qx_d[20]});
        fy = sy_f ? -$signed({2'b00, qy_d[20]}) - 1 : $signed({2'b00, qy_d[20]});
        fx = fx - (DivNW+2)'(16384);
        fy = fy - (DivNW+2)'(16384);
        ox = (fx > 32767) ? 16'h7FFF : (fx < -32768) ? 16'h8000 : 16'(fx);
        oy = (fy > 32767) ? 16'h7FFF : (fy < -32768) ? 16'h8000 : 16'(fy);
        fnum = num_out_reg;
        if (shn_reg[26][0])
        begin
            ou = (uq > 27'd65536) ? 17'd65536 : 17'(uq);
            ov = (vq > 27'd65536) ? 17'd65536 : 17'(vq);
        end
        else
        begin
            ou = ((fnum == 3'd1) || (fnum == 3'd3) || (fnum == 3'd4)) ? 17'd65536 : 17'd0;
            ov = ((fnum == 3'd2) || (fnum == 3'd4) || (fnum == 3'd5)) ? 17'd65536 : 17'd0;
        end
    end

    logic [2:0] nd_reg [27];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg[0] <= tnum_reg;
            for (int i = 1; i < 27; i++)
            begin
                nd_reg[i] <= nd_reg[i-1];
            end
            num_out_reg <= nd_reg[26];
        end
    end

    logic [OutWidth-1:0] od_reg;
    logic                ol_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= {3'b000, fnum, ov, ou, dep_d[60], oy, ox};
            ol_reg <= (fnum == 3'd5);
        end
    end
    assign m_tdata = od_reg;
    assign m_tlast = ol_reg;
endmodule

### rtl/core/sqvs_checker.sv
// Port-level checker for the sprite quad vertex setup core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sqvs_checker (
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic [87:0] m_tdata
);
    `CHK_IMPL(a_last_num, clk, rst_n, m_tvalid && m_tlast, m_tdata[84:82] == 3'd5, "last not on vertex five")
    `CHK_IMPL(a_num_range, clk, rst_n, m_tvalid, m_tdata[84:82] <= 3'd5, "vertex number out of range")
    `CHK_IMPL(a_tex_range, clk, rst_n, m_tvalid, m_tdata[64:48] <= 17'd65536, "texture u beyond one")
    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")
endmodule

bind sprite_quad_vertex_setup_core sqvs_checker u_sqvs_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tlast(m_tlast), .m_tdata(m_tdata)
);
